[src/assert_macros.svh]
// Assertion macros used by the checker file aluex_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AX_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define AX_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[src/aluex_pkg.sv]
// Types, codes and constant tables of the ALU execute block.
// No dependencies.
package aluex_pkg;

   typedef enum logic [4:0] {
      FN_ADD, FN_ADDC, FN_SUB, FN_SUBC, FN_DADD, FN_CMP, FN_XOR, FN_AND,
      FN_OR, FN_BIT, FN_BIC, FN_BIS, FN_MOV, FN_SWAP, FN_SRA, FN_RRC,
      FN_SWPB, FN_SXT, FN_MOVL, FN_MOVLZ, FN_MOVLS, FN_MOVH, FN_SETCC,
      FN_CLRCC, FN_CONDTEST
   } func_type;

   typedef enum logic [3:0] {
      CC_EQ, CC_NE, CC_CS, CC_CC, CC_MI, CC_PL, CC_VS, CC_VC,
      CC_HI, CC_LS, CC_GE, CC_LT, CC_GT, CC_LE, CC_TR, CC_FL
   } cond_type;

   localparam int FLAG_V   = 4;
   localparam int FLAG_SLP = 3;
   localparam int FLAG_N   = 2;
   localparam int FLAG_Z   = 1;
   localparam int FLAG_C   = 0;

   localparam logic [15:0] HIGH_MASK = 16'hFF00;
   localparam logic [15:0] BYTE_MASK = 16'h00FF;
   localparam logic [15:0] WORD_MASK = 16'hFFFF;
   localparam logic [4:0]  BCD_TEN   = 5'd10;

   // indexed by {src sign, dst sign, result sign}
   localparam logic [7:0] CARRY_TAB = 8'b1101_0100;
   localparam logic [7:0] OVF_TAB   = 8'b0100_0010;

   typedef struct packed {
      func_type    func;
      logic [15:0] src_value;
      logic [15:0] dst_value;
      logic        byte_mode;
      logic [7:0]  imm_byte;
      logic [4:0]  flag_mask;
      cond_type    cond_code;
   } req_type;

   typedef struct packed {
      logic [15:0] result_value;
      logic        write_dst;
      logic [15:0] swap_value;
      logic        write_src;
      logic        flag_v;
      logic        flag_slp;
      logic        flag_n;
      logic        flag_z;
      logic        flag_c;
      logic        cond_true;
   } rsp_type;

   function automatic logic [4:0] table_flags(logic sb, logic db, logic rb, logic zero,
                                              logic [4:0] flags);
      logic [2:0] idx;
      logic [4:0] f;
      idx            = {sb, db, rb};
      f              = '0;
      f[FLAG_SLP]    = flags[FLAG_SLP];
      f[FLAG_C]      = CARRY_TAB[idx];
      f[FLAG_V]      = OVF_TAB[idx];
      f[FLAG_N]      = rb;
      f[FLAG_Z]      = zero;
      return f;
   endfunction

   function automatic logic [4:0] nz_flags(logic [4:0] flags, logic n, logic zero);
      logic [4:0] f;
      f         = flags;
      f[FLAG_N] = n;
      f[FLAG_Z] = zero;
      return f;
   endfunction

   function automatic logic cond_eval(logic [4:0] f, cond_type cc);
      logic n, z, c, v, r;
      n = f[FLAG_N];
      z = f[FLAG_Z];
      c = f[FLAG_C];
      v = f[FLAG_V];
      unique case (cc)
         CC_EQ: r = z;
         CC_NE: r = !z;
         CC_CS: r = c;
         CC_CC: r = !c;
         CC_MI: r = n;
         CC_PL: r = !n;
         CC_VS: r = v;
         CC_VC: r = !v;
         CC_HI: r = c && !z;
         CC_LS: r = !c || z;
         CC_GE: r = (n == v);
         CC_LT: r = (n != v);
         CC_GT: r = !z && (n == v);
         CC_LE: r = z || (n != v);
         CC_TR: r = 1'b1;
         CC_FL: r = 1'b0;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

[src/aluex_core.sv]
// Combinational datapath: result, write enables, next flags, condition.
// Depends on aluex_pkg.
module aluex_core import aluex_pkg::*; (
   input  req_type    req,
   input  logic [4:0] flags,
   output rsp_type    rsp,
   output logic [4:0] flags_in
);

   logic [15:0] s, d, mask, sl, dl, nsl, keep;
   logic        bm, cin;
   logic [15:0] addend, arith_r, arith_op;
   logic        rc, opc;
   logic [15:0] dadd_r;
   logic [15:0] logic_r, sra_r, rrc_r, swpb_r, sxt_r;
   logic [15:0] res, sv;
   logic        wd, ws;
   logic [4:0]  nf;

   assign s    = req.src_value;
   assign d    = req.dst_value;
   assign bm   = req.byte_mode;
   assign mask = bm ? BYTE_MASK : WORD_MASK;
   assign sl   = s & mask;
   assign dl   = d & mask;
   assign nsl  = ~s & mask;
   assign keep = d & ~mask;
   assign cin  = flags[FLAG_C];

   always_comb begin
      case (req.func)
         FN_ADD:  begin addend = sl;  rc = 1'b0; opc = 1'b0; end
         FN_ADDC: begin addend = sl;  rc = cin;  opc = cin;  end
         FN_SUB:  begin addend = nsl; rc = 1'b1; opc = 1'b0; end
         FN_SUBC: begin addend = nsl; rc = cin;  opc = cin;  end
         default: begin addend = nsl; rc = 1'b1; opc = 1'b1; end
      endcase
   end

   assign arith_r  = (dl + addend + {15'd0, rc}) & mask;
   assign arith_op = (addend + {15'd0, opc}) & mask;

   // nibble-serial BCD add, carry ripples low to high
   always_comb begin
      logic [4:0] t;
      logic       c;
      dadd_r = d;
      c      = cin;
      for (int k = 0; k < 4; k++) begin
         if (k < 2 || !bm) begin
            t = {1'b0, s[4*k +: 4]} + {1'b0, d[4*k +: 4]} + {4'd0, c};
            if (t >= BCD_TEN) begin
               t = t - BCD_TEN;
               c = 1'b1;
            end else begin
               c = 1'b0;
            end
            dadd_r[4*k +: 4] = t[3:0];
         end
      end
   end

   always_comb begin
      case (req.func)
         FN_XOR:  logic_r = dl ^ sl;
         FN_AND:  logic_r = dl & sl;
         FN_BIC:  logic_r = dl & nsl;
         default: logic_r = dl | sl;
      endcase
   end

   assign sra_r  = bm ? {8'd0, dl[7], dl[7:1]} : {dl[15], dl[15:1]};
   assign rrc_r  = bm ? {8'd0, cin, dl[7:1]} : {cin, dl[15:1]};
   assign swpb_r = {d[7:0], d[15:8]};
   assign sxt_r  = {{8{d[7]}}, d[7:0]};

   always_comb begin
      logic [4:0] rf;
      rf  = flags;
      res = d;
      sv  = '0;
      wd  = 1'b0;
      ws  = 1'b0;
      nf  = flags;
      unique case (req.func) inside
         FN_ADD, FN_ADDC, FN_SUB, FN_SUBC, FN_CMP: begin
            nf = table_flags(bm ? arith_op[7] : arith_op[15], bm ? dl[7] : dl[15],
                             bm ? arith_r[7] : arith_r[15], arith_r == '0, flags);
            if (req.func != FN_CMP) begin
               res = keep | arith_r;
               wd  = 1'b1;
            end
         end
         FN_DADD: begin
            nf  = table_flags(bm ? s[7] : s[15], bm ? dadd_r[7] : dadd_r[15],
                              bm ? dadd_r[7] : dadd_r[15], dadd_r == '0, flags);
            res = dadd_r;
            wd  = 1'b1;
         end
         FN_XOR, FN_AND, FN_OR, FN_BIC, FN_BIS: begin
            nf  = nz_flags(flags, bm ? logic_r[7] : logic_r[15], logic_r == '0);
            res = keep | logic_r;
            wd  = 1'b1;
         end
         FN_BIT: begin
            nf[FLAG_Z] = (dl & sl) == '0;
         end
         FN_MOV: begin
            res = keep | sl;
            wd  = 1'b1;
         end
         FN_SWAP: begin
            res = s;
            sv  = d;
            wd  = 1'b1;
            ws  = 1'b1;
         end
         FN_SRA: begin
            nf  = nz_flags(flags, bm ? sra_r[7] : sra_r[15], sra_r == '0);
            res = keep | sra_r;
            wd  = 1'b1;
         end
         FN_RRC: begin
            rf[FLAG_C] = dl[0];
            nf  = nz_flags(rf, bm ? rrc_r[7] : rrc_r[15], rrc_r == '0);
            res = keep | rrc_r;
            wd  = 1'b1;
         end
         FN_SWPB: begin
            nf  = nz_flags(flags, swpb_r[15], swpb_r == '0);
            res = swpb_r;
            wd  = 1'b1;
         end
         FN_SXT: begin
            nf  = nz_flags(flags, sxt_r[15], sxt_r == '0);
            res = sxt_r;
            wd  = 1'b1;
         end
         FN_MOVL: begin
            res = {d[15:8], req.imm_byte};
            wd  = 1'b1;
         end
         FN_MOVLZ: begin
            res = {8'h00, req.imm_byte};
            wd  = 1'b1;
         end
         FN_MOVLS: begin
            res = {8'hFF, req.imm_byte};
            wd  = 1'b1;
         end
         FN_MOVH: begin
            res = {req.imm_byte, d[7:0]};
            wd  = 1'b1;
         end
         FN_SETCC: nf = flags | req.flag_mask;
         FN_CLRCC: nf = flags & ~req.flag_mask;
         default: ;
      endcase
   end

   assign flags_in = nf;

   always_comb begin
      rsp.result_value = res;
      rsp.write_dst    = wd;
      rsp.swap_value   = sv;
      rsp.write_src    = ws;
      rsp.flag_v       = nf[FLAG_V];
      rsp.flag_slp     = nf[FLAG_SLP];
      rsp.flag_n       = nf[FLAG_N];
      rsp.flag_z       = nf[FLAG_Z];
      rsp.flag_c       = nf[FLAG_C];
      rsp.cond_true    = cond_eval(flags, req.cond_code);
   end

endmodule

[src/alu_execute_with_status_flags.sv]
// Top level of the ALU execute block: input register, datapath, result register.
// Depends on aluex_pkg and aluex_core.
//
//   channel | direction | handshake            | beat
//   req     | in        | req_valid/req_ready  | req_type: operation and operands
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_type: result, enables, flags
//
// One beat per cycle sustained while rsp_ready is high; rsp_valid rises once the beat has passed both registers.
// Latency is set by the input register and the result register around the datapath.
// Flags update as a beat moves from the input register into the result register.
// Reset clears both valid bits and the flags.
// A stalled result holds both stages; the input register still fills if empty.
module alu_execute_with_status_flags import aluex_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic       s1_valid_ff, s1_valid_in;
   req_type    s1_data_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff;
   logic [4:0] flags_ff, flags_in;
   rsp_type    core_rsp;
   logic       out_free, s1_move;

   aluex_core u_core (
      .req      (s1_data_ff),
      .flags    (flags_ff),
      .rsp      (core_rsp),
      .flags_in (flags_in)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;

   assign s1_valid_in  = (req_valid && req_ready) || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_move) begin
            flags_ff <= flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (s1_move) begin
         rsp_data_ff <= core_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[src/aluex_checker.sv]
// Port-level checks for the ALU execute block, bound to the top level.
// Depends on aluex_pkg and assert_macros.svh.
`include "assert_macros.svh"

module aluex_checker import aluex_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `AX_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `AX_IMPL(a_src_needs_dst, clock, reset, rsp_valid && rsp_data.write_src, rsp_data.write_dst)
   `AX_IMPL(a_swap_zero, clock, reset, rsp_valid && !rsp_data.write_src, rsp_data.swap_value == '0)
   `AX_IMPL(a_no_bubble, clock, reset, rsp_ready, req_ready)
   `AX_IMPL(a_reset_empty, clock, reset, $past(reset), !rsp_valid)

endmodule

bind alu_execute_with_status_flags aluex_checker u_checker (.*);

[tb/sv/alu_execute_with_status_flags_test.sv]
// Self-checking testbench for the ALU execute block: directed and random beats,
// predicted results with carried flags, random idling on both channels.
// Depends on aluex_pkg and alu_execute_with_status_flags.
module alu_execute_with_status_flags_test import aluex_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [4:0] FUNC_UNUSED_FIRST = 5'd25;
   localparam logic [4:0] FUNC_UNUSED_LAST  = 5'd31;
   localparam int         RANDOM_ITEMS      = 600;
   localparam int         LONG_HOLD_CYCLES  = 60;

   class exec_checker;
      // {src sign, dst sign, result sign} -> carry / overflow
      localparam bit [7:0] CARRY_BY_SIGNS = 8'b1101_0100;
      localparam bit [7:0] OVF_BY_SIGNS   = 8'b0100_0010;

      logic [4:0] flags_now;
      rsp_type    expected_results[$];
      int         mismatches;

      function new();
         flags_now  = '0;
         mismatches = 0;
      endfunction

      function void apply_sign_table(logic sb, logic db, logic rb, logic zero);
         logic [2:0] idx;
         logic       slp;
         idx                = {sb, db, rb};
         slp                = flags_now[FLAG_SLP];
         flags_now          = '0;
         flags_now[FLAG_SLP] = slp;
         flags_now[FLAG_C]  = CARRY_BY_SIGNS[idx];
         flags_now[FLAG_V]  = OVF_BY_SIGNS[idx];
         flags_now[FLAG_N]  = rb;
         flags_now[FLAG_Z]  = zero;
      endfunction

      function void apply_nz(logic n, logic zero);
         flags_now[FLAG_N] = n;
         flags_now[FLAG_Z] = zero;
      endfunction

      function logic cond_holds(cond_type cc);
         logic n, z, c, v;
         n = flags_now[FLAG_N];
         z = flags_now[FLAG_Z];
         c = flags_now[FLAG_C];
         v = flags_now[FLAG_V];
         case (cc)
            CC_EQ: return z;
            CC_NE: return !z;
            CC_CS: return c;
            CC_CC: return !c;
            CC_MI: return n;
            CC_PL: return !n;
            CC_VS: return v;
            CC_VC: return !v;
            CC_HI: return c && !z;
            CC_LS: return !c || z;
            CC_GE: return n == v;
            CC_LT: return n != v;
            CC_GT: return !z && (n == v);
            CC_LE: return z || (n != v);
            CC_TR: return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      function void predict_exec(req_type q);
         rsp_type     e;
         logic [15:0] mask, top, keep, sl, dl, nsl, r, op, bcd;
         logic [4:0]  t;
         logic        cin, cy;
         int          sh, k;
         mask = q.byte_mode ? 16'h00FF : 16'hFFFF;
         top  = q.byte_mode ? 16'h0080 : 16'h8000;
         sh   = q.byte_mode ? 7 : 15;
         sl   = q.src_value & mask;
         dl   = q.dst_value & mask;
         keep = q.dst_value & ~mask;
         nsl  = ~q.src_value & mask;
         cin  = flags_now[FLAG_C];
         e    = '0;
         e.result_value = q.dst_value;
         e.cond_true    = cond_holds(q.cond_code);
         case (q.func)
            FN_ADD, FN_ADDC, FN_SUB, FN_SUBC, FN_CMP: begin
               case (q.func)
                  FN_ADD: begin
                     op = sl;
                     r  = dl + sl;
                  end
                  FN_ADDC: begin
                     op = (sl + cin) & mask;
                     r  = dl + sl + cin;
                  end
                  FN_SUB: begin
                     op = nsl;
                     r  = dl + nsl + 16'd1;
                  end
                  FN_SUBC: begin
                     op = (nsl + cin) & mask;
                     r  = dl + nsl + cin;
                  end
                  default: begin
                     op = (nsl + 16'd1) & mask;
                     r  = dl + nsl + 16'd1;
                  end
               endcase
               r = r & mask;
               apply_sign_table(op[sh], dl[sh], r[sh], r == 16'h0000);
               if (q.func != FN_CMP) begin
                  e.result_value = keep | r;
                  e.write_dst    = 1'b1;
               end
            end
            FN_DADD: begin
               bcd = q.dst_value;
               cy  = cin;
               for (k = 0; k < (q.byte_mode ? 2 : 4); k++) begin
                  t = {1'b0, q.src_value[4*k +: 4]} + {1'b0, q.dst_value[4*k +: 4]} + cy;
                  if (t >= 5'd10) begin
                     t  = t - 5'd10;
                     cy = 1'b1;
                  end else begin
                     cy = 1'b0;
                  end
                  bcd[4*k +: 4] = t[3:0];
               end
               apply_sign_table(q.src_value[sh], bcd[sh], bcd[sh], bcd == 16'h0000);
               e.result_value = bcd;
               e.write_dst    = 1'b1;
            end
            FN_XOR, FN_AND, FN_OR, FN_BIC, FN_BIS: begin
               case (q.func)
                  FN_XOR:  r = dl ^ sl;
                  FN_AND:  r = dl & sl;
                  FN_BIC:  r = dl & nsl;
                  default: r = dl | sl;
               endcase
               r = r & mask;
               apply_nz(r[sh], r == 16'h0000);
               e.result_value = keep | r;
               e.write_dst    = 1'b1;
            end
            FN_BIT: flags_now[FLAG_Z] = (dl & sl) == 16'h0000;
            FN_MOV: begin
               e.result_value = keep | sl;
               e.write_dst    = 1'b1;
            end
            FN_SWAP: begin
               e.result_value = q.src_value;
               e.swap_value   = q.dst_value;
               e.write_dst    = 1'b1;
               e.write_src    = 1'b1;
            end
            FN_SRA, FN_RRC: begin
               if (q.func == FN_SRA) begin
                  r = ((dl >> 1) | (dl & top)) & mask;
               end else begin
                  r = ((dl >> 1) | (cin ? top : 16'h0000)) & mask;
                  flags_now[FLAG_C] = dl[0];
               end
               apply_nz(r[sh], r == 16'h0000);
               e.result_value = keep | r;
               e.write_dst    = 1'b1;
            end
            FN_SWPB, FN_SXT: begin
               if (q.func == FN_SWPB)
                  r = {q.dst_value[7:0], q.dst_value[15:8]};
               else
                  r = {{8{q.dst_value[7]}}, q.dst_value[7:0]};
               apply_nz(r[15], r == 16'h0000);
               e.result_value = r;
               e.write_dst    = 1'b1;
            end
            FN_MOVL: begin
               e.result_value = {q.dst_value[15:8], q.imm_byte};
               e.write_dst    = 1'b1;
            end
            FN_MOVLZ: begin
               e.result_value = {8'h00, q.imm_byte};
               e.write_dst    = 1'b1;
            end
            FN_MOVLS: begin
               e.result_value = {8'hFF, q.imm_byte};
               e.write_dst    = 1'b1;
            end
            FN_MOVH: begin
               e.result_value = {q.imm_byte, q.dst_value[7:0]};
               e.write_dst    = 1'b1;
            end
            FN_SETCC: flags_now = flags_now | q.flag_mask;
            FN_CLRCC: flags_now = flags_now & ~q.flag_mask;
            default: ;
         endcase
         e.flag_v   = flags_now[FLAG_V];
         e.flag_slp = flags_now[FLAG_SLP];
         e.flag_n   = flags_now[FLAG_N];
         e.flag_z   = flags_now[FLAG_Z];
         e.flag_c   = flags_now[FLAG_C];
         expected_results.push_back(e);
      endfunction

      function string show(rsp_type r);
         return $sformatf("res=%h wd=%b swap=%h ws=%b VSNZC=%b%b%b%b%b cond=%b",
                          r.result_value, r.write_dst, r.swap_value, r.write_src,
                          r.flag_v, r.flag_slp, r.flag_n, r.flag_z, r.flag_c, r.cond_true);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         string   bad;
         if (expected_results.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: result beat with nothing pending: %s", $realtime, show(got));
            mismatches++;
            return;
         end
         e   = expected_results.pop_front();
         bad = "";
         if (got.result_value !== e.result_value) bad = {bad, " result_value"};
         if (got.write_dst !== e.write_dst)       bad = {bad, " write_dst"};
         if (got.swap_value !== e.swap_value)     bad = {bad, " swap_value"};
         if (got.write_src !== e.write_src)       bad = {bad, " write_src"};
         if (got.flag_v !== e.flag_v)             bad = {bad, " flag_v"};
         if (got.flag_slp !== e.flag_slp)         bad = {bad, " flag_slp"};
         if (got.flag_n !== e.flag_n)             bad = {bad, " flag_n"};
         if (got.flag_z !== e.flag_z)             bad = {bad, " flag_z"};
         if (got.flag_c !== e.flag_c)             bad = {bad, " flag_c"};
         if (got.cond_true !== e.cond_true)       bad = {bad, " cond_true"};
         if (bad != "") begin
            if (mismatches < 10)
               $display("%0t: mismatch in%s\n  expected %s\n  actual   %s",
                        $realtime, bad, show(e), show(got));
            mismatches++;
         end
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   bit quiet     = 1'b0;
   bit hold_long = 1'b0;

   exec_checker board = new();

   alu_execute_with_status_flags dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.predict_exec(req_data);
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
      end
   end

   function automatic req_type mk(func_type f, logic [15:0] s, logic [15:0] d, logic bm,
                                  logic [7:0] imm, logic [4:0] fm, cond_type cc);
      req_type q;
      q.func      = f;
      q.src_value = s;
      q.dst_value = d;
      q.byte_mode = bm;
      q.imm_byte  = imm;
      q.flag_mask = fm;
      q.cond_code = cc;
      return q;
   endfunction

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h7FFF;
         3: return 16'h8000;
         4: return 16'h00FF;
         5: return 16'h0080;
         default: return 16'($urandom);
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after the beat is taken
   task automatic send_beat(req_type q);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_long) begin
            hold_long = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   initial begin
      #500000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      req_type q;
      int      sent;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_beat(mk(FN_SETCC,    16'h0000, 16'h0000, 1'b0, 8'h00, 5'h1F, CC_EQ));
      send_beat(mk(FN_CONDTEST, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 5'h00, CC_LE));
      send_beat(mk(FN_ADD,      16'h0001, 16'h7FFF, 1'b0, 8'h00, 5'h00, CC_GT));
      send_beat(mk(FN_ADDC,     16'h0001, 16'hFFFF, 1'b0, 8'h00, 5'h00, CC_HI));
      send_beat(mk(FN_SUB,      16'h0001, 16'hAB00, 1'b1, 8'h00, 5'h00, CC_CS));
      send_beat(mk(FN_SUBC,     16'hFFFF, 16'h0000, 1'b0, 8'h00, 5'h00, CC_LS));
      send_beat(mk(FN_DADD,     16'h9999, 16'h0001, 1'b0, 8'h00, 5'h00, CC_VS));
      send_beat(mk(FN_DADD,     16'h0099, 16'h1201, 1'b1, 8'h00, 5'h00, CC_VC));
      send_beat(mk(FN_CMP,      16'h8000, 16'h8000, 1'b0, 8'h00, 5'h00, CC_GE));
      send_beat(mk(FN_XOR,      16'hFFFF, 16'hA5A5, 1'b1, 8'h00, 5'h00, CC_LT));
      send_beat(mk(FN_AND,      16'hF0F0, 16'hFFFF, 1'b0, 8'h00, 5'h00, CC_MI));
      send_beat(mk(FN_OR,       16'h0000, 16'h0000, 1'b0, 8'h00, 5'h00, CC_PL));
      send_beat(mk(FN_BIT,      16'h00FF, 16'hFF00, 1'b0, 8'h00, 5'h00, CC_NE));
      send_beat(mk(FN_BIC,      16'hFFFF, 16'h1234, 1'b1, 8'h00, 5'h00, CC_CC));
      send_beat(mk(FN_BIS,      16'h0080, 16'h0000, 1'b1, 8'h00, 5'h00, CC_TR));
      send_beat(mk(FN_MOV,      16'hABCD, 16'h1234, 1'b1, 8'h00, 5'h00, CC_FL));
      send_beat(mk(FN_SWAP,     16'hFFFF, 16'h0000, 1'b0, 8'h00, 5'h00, CC_EQ));
      send_beat(mk(FN_SRA,      16'h0000, 16'h1280, 1'b1, 8'h00, 5'h00, CC_MI));
      send_beat(mk(FN_RRC,      16'h0000, 16'h0001, 1'b0, 8'h00, 5'h00, CC_CS));
      send_beat(mk(FN_SWPB,     16'h0000, 16'h00FF, 1'b0, 8'h00, 5'h00, CC_EQ));
      send_beat(mk(FN_SXT,      16'h0000, 16'h0080, 1'b0, 8'h00, 5'h00, CC_MI));
      send_beat(mk(FN_MOVL,     16'h0000, 16'hFFFF, 1'b0, 8'h00, 5'h00, CC_TR));
      send_beat(mk(FN_MOVLZ,    16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 5'h00, CC_TR));
      send_beat(mk(FN_MOVLS,    16'h0000, 16'h0000, 1'b0, 8'h00, 5'h00, CC_TR));
      send_beat(mk(FN_MOVH,     16'h0000, 16'h0000, 1'b0, 8'hFF, 5'h00, CC_TR));
      send_beat(mk(FN_CLRCC,    16'h0000, 16'h0000, 1'b0, 8'h00, 5'h1F, CC_NE));
      send_beat(mk(func_type'(FUNC_UNUSED_LAST), 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF,
                   5'h1F, CC_FL));

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent == 100) hold_long = 1'b1;
         if (sent == RANDOM_ITEMS - 100) quiet = 1'b1;
         if ($urandom_range(0, 19) == 0)
            q.func = func_type'(5'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST)));
         else
            q.func = func_type'(5'($urandom_range(0, FN_CONDTEST)));
         q.src_value = pick_word();
         q.dst_value = pick_word();
         q.byte_mode = 1'($urandom_range(0, 1));
         q.imm_byte  = 8'($urandom);
         q.flag_mask = 5'($urandom);
         q.cond_code = cond_type'(4'($urandom_range(0, 15)));
         send_beat(q);
         if (q.func <= FN_CONDTEST) sent++;
      end
      req_valid <= 1'b0;

      while (board.expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.mismatches == 0 && board.expected_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

[filelist.f]
+incdir+src
src/aluex_pkg.sv
src/aluex_core.sv
src/alu_execute_with_status_flags.sv
src/aluex_checker.sv
tb/sv/alu_execute_with_status_flags_test.sv
